/* hdl/opt_pkg.sv */
`default_nettype none

package opt_pkg;

  // Field widths of the item and result channels.
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned COUNT_W = 5;

  // Operation codes carried by the mode field.
  localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACK    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXPIRE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  // One table entry as it is kept in the entry memory.
  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic [KEY_W-1:0]  key;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* hdl/ordered_pending_table.sv */
`default_nettype none

// Ordered pending table: an age-ordered table of up to CAPACITY entries, each
// a tick stamp and a key. An item on the input channel (mode, tick, key)
// records, acks, expires or clears, and each item gives exactly one result
// (found, evicted, count) on the output channel. Both channels use valid and
// ready. The block takes one item at a time: in_ready_o is high only while
// the sequencer is idle.
// Record and clear, like ack and expire on an empty table, go from idle
// directly to the final state, which loads the output register. Ack and
// expire stream every valid entry through the single read port of the entry
// memory, one entry per cycle, and compact the survivors through the write
// port behind the reads before they reach the final state. The next item is
// taken once the sequencer is back in idle. A full-table record is a single
// write because the table is kept as a ring with a head pointer.
// Reset empties the table at once: only the fill count and head pointer are
// cleared, and the memory is never read beyond the fill count.
// A finished result sits in an output register; if the receiver stalls,
// the sequencer waits in its final state and the next item is not taken
// until the held result has been delivered.

module ordered_pending_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [opt_pkg::MODE_W-1:0]       mode_i,
  input  wire logic [opt_pkg::TICK_W-1:0]       tick_i,
  input  wire logic [opt_pkg::KEY_W-1:0]        key_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  found_o,
  output logic                                  evicted_o,
  output logic      [opt_pkg::COUNT_W-1:0]      count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = AW + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // Advance a ring pointer, wrapping at the table capacity.
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  // Control state.
  logic [1:0]    state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;

  // Working registers of the current operation.
  logic [opt_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [opt_pkg::TICK_W-1:0] tick_q, tick_d;
  logic [opt_pkg::KEY_W-1:0]  key_q, key_d;
  logic [CW-1:0]              rd_idx_q, rd_idx_d;
  logic [AW-1:0]              rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]              wr_ptr_q, wr_ptr_d;
  logic [CW-1:0]              wr_cnt_q, wr_cnt_d;
  logic                       data_vld_q, data_vld_d;
  logic                       found_q, found_d;
  logic                       evicted_q, evicted_d;

  // Result register.
  logic                         found_out_q, found_out_d;
  logic                         evicted_out_q, evicted_out_d;
  logic [opt_pkg::COUNT_W-1:0]  count_out_q, count_out_d;

  // Entry memory ports.
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  opt_pkg::entry_t       ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  opt_pkg::entry_t       ram_rdata;

  logic                  full;
  logic [SW-1:0]         tail_sum;
  logic [AW-1:0]         tail_ptr;
  logic                  drop;
  logic [CW+4:0]         count_wide;

  assign full     = (count_q == CW'(CAPACITY));
  assign tail_sum = SW'(head_q) + SW'(count_q);
  assign tail_ptr = (tail_sum >= SW'(CAPACITY)) ? AW'(tail_sum - SW'(CAPACITY))
                                                : AW'(tail_sum);

  // Ack drops only the first matching key; expire drops every stale tick.
  always_comb begin
    if (mode_q == opt_pkg::MODE_ACK) begin
      drop = !found_q && (ram_rdata.key == key_q);
    end else begin
      drop = (ram_rdata.tick < tick_q);
    end
  end

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    count_d       = count_q;
    out_valid_d   = out_valid_q;
    mode_d        = mode_q;
    tick_d        = tick_q;
    key_d         = key_q;
    rd_idx_d      = rd_idx_q;
    rd_ptr_d      = rd_ptr_q;
    wr_ptr_d      = wr_ptr_q;
    wr_cnt_d      = wr_cnt_q;
    data_vld_d    = data_vld_q;
    found_d       = found_q;
    evicted_d     = evicted_q;
    found_out_d   = found_out_q;
    evicted_out_d = evicted_out_q;
    count_out_d   = count_out_q;
    count_wide    = {{5{1'b0}}, count_q};
    ram_we        = 1'b0;
    ram_waddr     = wr_ptr_q;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = rd_ptr_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d     = mode_i;
          tick_d     = tick_i;
          key_d      = key_i;
          found_d    = 1'b0;
          evicted_d  = 1'b0;
          rd_idx_d   = '0;
          rd_ptr_d   = head_q;
          wr_ptr_d   = head_q;
          wr_cnt_d   = '0;
          data_vld_d = 1'b0;
          unique case (mode_i) inside
            opt_pkg::MODE_RECORD: begin
              ram_we         = 1'b1;
              ram_wdata.tick = tick_i;
              ram_wdata.key  = key_i;
              if (full) begin
                // The oldest entry sits where the new one goes.
                ram_waddr = head_q;
                head_d    = ptr_inc(head_q);
                evicted_d = 1'b1;
              end else begin
                ram_waddr = tail_ptr;
                count_d   = count_q + CW'(1);
              end
              state_d = ST_FIN;
            end
            opt_pkg::MODE_ACK, opt_pkg::MODE_EXPIRE: begin
              state_d = (count_q == '0) ? ST_FIN : ST_SCAN;
            end
            opt_pkg::MODE_CLEAR: begin
              count_d = '0;
              head_d  = '0;
              state_d = ST_FIN;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the read of the next entry while the previous one is judged.
        if (rd_idx_q != count_q) begin
          ram_re     = 1'b1;
          ram_raddr  = rd_ptr_q;
          rd_ptr_d   = ptr_inc(rd_ptr_q);
          rd_idx_d   = rd_idx_q + CW'(1);
          data_vld_d = 1'b1;
        end else begin
          data_vld_d = 1'b0;
        end

        // Survivors are written back at the compaction pointer, which never
        // passes the read pointer.
        if (data_vld_q) begin
          if (drop) begin
            if (mode_q == opt_pkg::MODE_ACK) begin
              found_d = 1'b1;
            end
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wr_ptr_q;
            ram_wdata = ram_rdata;
            wr_ptr_d  = ptr_inc(wr_ptr_q);
            wr_cnt_d  = wr_cnt_q + CW'(1);
          end
        end

        if ((rd_idx_q == count_q) && !data_vld_q) begin
          count_d = wr_cnt_q;
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          found_out_d   = found_q;
          evicted_out_d = evicted_q;
          count_out_d   = count_wide[4:0];
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q        <= mode_d;
    tick_q        <= tick_d;
    key_q         <= key_d;
    rd_idx_q      <= rd_idx_d;
    rd_ptr_q      <= rd_ptr_d;
    wr_ptr_q      <= wr_ptr_d;
    wr_cnt_q      <= wr_cnt_d;
    data_vld_q    <= data_vld_d;
    found_q       <= found_d;
    evicted_q     <= evicted_d;
    found_out_q   <= found_out_d;
    evicted_out_q <= evicted_out_d;
    count_out_q   <= count_out_d;
  end

  opt_ram #(
    .WIDTH (opt_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign found_o     = found_out_q;
  assign evicted_o   = evicted_out_q;
  assign count_o     = count_out_q;

  // The fill count never exceeds the table capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // Compaction writes never overtake the reads of the same pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (wr_cnt_q <= rd_idx_q))
    else $error("compaction pointer passed read pointer");

  // A result never reports both a match and an eviction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && evicted_o))
    else $error("found and evicted both set");

  // A result is loaded only as the sequencer returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && (!out_valid_q || out_ready_i)) |=>
      (out_valid_q && state_q == ST_IDLE))
    else $error("result not published on completion");

endmodule

`default_nettype wire

/* hdl/opt_ram.sv */
`default_nettype none

module opt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  // The block under test keeps this many entries; the shadow table matches it.
  localparam int unsigned TABLE_DEPTH = 16;

  // Generous ceiling on the run. The slowest correct run is roughly 525 items,
  // each with the longest sender idle burst, a full table scan and the longest
  // receiver stall, plus the long receiver hold-off.
  localparam int unsigned LIMIT_CYCLES = 200000;

  // Number of random items after the directed part.
  localparam int unsigned RANDOM_ITEMS = 500;

  // Items left in the queue below which nobody idles any more.
  localparam int unsigned CALM_TAIL = 60;

  // Length of the long receiver hold-off that fills the block up.
  localparam int unsigned HOLD_CYCLES = 400;

  // One input item as the sender presents it.
  typedef struct packed {
    logic [opt_pkg::MODE_W-1:0] mode;
    logic [opt_pkg::TICK_W-1:0] tick;
    logic [opt_pkg::KEY_W-1:0]  key;
  } table_op_t;

  // One result as the block returns it.
  typedef struct packed {
    logic                        found;
    logic                        evicted;
    logic [opt_pkg::COUNT_W-1:0] count;
  } table_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Inputs of the block start at known values before the first edge.
  logic                        in_valid = 1'b0;
  logic [opt_pkg::MODE_W-1:0]  op_mode = '0;
  logic [opt_pkg::TICK_W-1:0]  op_tick = '0;
  logic [opt_pkg::KEY_W-1:0]   op_key = '0;
  logic                        out_ready = 1'b0;

  logic                        in_ready_o;
  logic                        out_valid_o;
  logic                        found_o;
  logic                        evicted_o;
  logic [opt_pkg::COUNT_W-1:0] count_o;

  ordered_pending_table #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .mode_i     (op_mode),
    .tick_i     (op_tick),
    .key_i      (op_key),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .found_o    (found_o),
    .evicted_o  (evicted_o),
    .count_o    (count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Items waiting to be offered, and the results the shadow table has worked
  // out for items the block has already taken.
  table_op_t     pending_items[$];
  table_result_t expected_results[$];

  // Shadow copy of the table: slot 0 holds the oldest entry.
  logic [opt_pkg::TICK_W-1:0] shadow_tick[TABLE_DEPTH];
  logic [opt_pkg::KEY_W-1:0]  shadow_key[TABLE_DEPTH];
  int unsigned                shadow_fill = 0;

  int unsigned mismatches = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;

  initial begin
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      shadow_tick[s] = '0;
      shadow_key[s] = '0;
    end
  end

  // Applies one item to the shadow table and returns the result the block
  // must give for it.
  function automatic table_result_t table_apply(input table_op_t op);
    table_result_t r;
    logic          hit;
    int            hit_idx;
    int            wr;
    r = '0;
    hit = 1'b0;
    hit_idx = 0;
    wr = 0;
    case (op.mode)
      opt_pkg::MODE_RECORD: begin
        // A full table drops its oldest entry before the new one goes in.
        if (shadow_fill >= TABLE_DEPTH) begin
          for (int i = 1; i < TABLE_DEPTH; i++) begin
            shadow_tick[i-1] = shadow_tick[i];
            shadow_key[i-1] = shadow_key[i];
          end
          shadow_fill = TABLE_DEPTH - 1;
          r.evicted = 1'b1;
        end
        shadow_tick[shadow_fill] = op.tick;
        shadow_key[shadow_fill] = op.key;
        shadow_fill++;
      end
      opt_pkg::MODE_ACK: begin
        // Only the oldest matching entry goes; younger ones close the gap.
        for (int i = 0; i < shadow_fill; i++) begin
          if (!hit && shadow_key[i] == op.key) begin
            hit = 1'b1;
            hit_idx = i;
          end
        end
        if (hit) begin
          for (int i = hit_idx + 1; i < shadow_fill; i++) begin
            shadow_tick[i-1] = shadow_tick[i];
            shadow_key[i-1] = shadow_key[i];
          end
          shadow_tick[shadow_fill-1] = '0;
          shadow_key[shadow_fill-1] = '0;
          shadow_fill--;
        end
        r.found = hit;
      end
      opt_pkg::MODE_EXPIRE: begin
        // Survivors have tick >= cutoff, plain unsigned, and keep their order.
        for (int i = 0; i < shadow_fill; i++) begin
          if (shadow_tick[i] >= op.tick) begin
            shadow_tick[wr] = shadow_tick[i];
            shadow_key[wr] = shadow_key[i];
            wr++;
          end
        end
        for (int i = wr; i < shadow_fill; i++) begin
          shadow_tick[i] = '0;
          shadow_key[i] = '0;
        end
        shadow_fill = wr;
      end
      default: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          shadow_tick[i] = '0;
          shadow_key[i] = '0;
        end
        shadow_fill = 0;
      end
    endcase
    r.count = shadow_fill[opt_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at result %0d: %s got %0h want %0h",
             results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic add_item(input logic [opt_pkg::MODE_W-1:0] mode,
                          input logic [opt_pkg::TICK_W-1:0] tick,
                          input logic [opt_pkg::KEY_W-1:0] key);
    table_op_t op;
    op.mode = mode;
    op.tick = tick;
    op.key = key;
    pending_items.push_back(op);
  endtask

  // Idling is allowed except near the end of the run and in every third
  // window of 64 items, which leaves stretches at full rate in the middle.
  function automatic logic idle_allowed();
    return (pending_items.size() >= CALM_TAIL) && (((items_taken / 64) % 3) != 2);
  endfunction

  // Sender. An item taken at this edge is fed to the shadow table right away;
  // the next item, or an idle burst, is set up in the same step with a single
  // assignment to the valid line.
  table_op_t   offered_op;
  int unsigned send_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      op_mode <= opt_pkg::MODE_RECORD;
      op_tick <= '0;
      op_key <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_results.push_back(table_apply(offered_op));
        items_taken++;
      end
      if (!in_valid || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          offered_op = pending_items.pop_front();
          in_valid <= 1'b1;
          op_mode <= offered_op.mode;
          op_tick <= offered_op.tick;
          op_key <= offered_op.key;
          // The burst, if any, starts once this item has been taken.
          if (idle_allowed() && $urandom_range(0, 3) == 0) begin
            send_gap <= $urandom_range(1, 16);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the receiver, counted down in its own process. The
  // sender keeps offering meanwhile, so the held result backs the block up
  // and its input stalls.
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= 80) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver and checker. Every accepted result is matched, field by field,
  // against the oldest expectation.
  table_result_t want_result;
  int unsigned   stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no item outstanding", 32'(count_o), 32'd0);
        end else begin
          want_result = expected_results.pop_front();
          if (found_o !== want_result.found) begin
            report_mismatch("found", 32'(found_o), 32'(want_result.found));
          end
          if (evicted_o !== want_result.evicted) begin
            report_mismatch("evicted", 32'(evicted_o), 32'(want_result.evicted));
          end
          if (count_o !== want_result.count) begin
            report_mismatch("count", 32'(count_o), 32'(want_result.count));
          end
        end
        results_seen++;
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (idle_allowed() && $urandom_range(0, 4) == 0) begin
        // The stall begins in this cycle and goes on while stall_left counts down.
        stall_left <= $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("ordered_pending_table test failed");
      $finish;
    end
  end

  // Stimulus and end of run.
  logic [opt_pkg::KEY_W-1:0]  key_pool[8];
  logic [opt_pkg::TICK_W-1:0] now_tick;
  int unsigned                rec_weight;
  int unsigned                roll;

  initial begin
    // Directed part. Empty-table cases come first: ack with no entries,
    // expire with nothing to remove, and clear of an already empty table.
    add_item(opt_pkg::MODE_ACK, '0, '0);
    add_item(opt_pkg::MODE_EXPIRE, '1, '1);
    add_item(opt_pkg::MODE_CLEAR, '1, '1);
    // Fill to capacity with extreme ticks and keys at both ends; the
    // seventeenth record lands on a full table and evicts the oldest.
    add_item(opt_pkg::MODE_RECORD, '0, '0);
    add_item(opt_pkg::MODE_RECORD, '1, '1);
    for (int i = 2; i < TABLE_DEPTH + 1; i++) begin
      add_item(opt_pkg::MODE_RECORD, 32'h100 * i, 32'hA5A5_0000 + i);
    end
    // Ack a key in the middle, then a key that is not present.
    add_item(opt_pkg::MODE_ACK, '0, 32'hA5A5_0008);
    add_item(opt_pkg::MODE_ACK, '0, 32'h5A5A_FFFF);
    // Cutoff of zero keeps all; a middle cutoff removes the older part;
    // the all-ones cutoff keeps only ticks equal to it.
    add_item(opt_pkg::MODE_EXPIRE, '0, '0);
    add_item(opt_pkg::MODE_EXPIRE, 32'h0000_0A00, '0);
    add_item(opt_pkg::MODE_EXPIRE, '1, '0);
    add_item(opt_pkg::MODE_CLEAR, '0, '0);

    // Random part. Keys come mostly from a small pool so that acks find
    // their entries, and ticks mostly advance like a clock so that expire
    // cutoffs fall among the stored entries. Record-heavy and balanced
    // windows alternate so the table spends time both full and sparse.
    now_tick = $urandom;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        for (int j = 0; j < 8; j++) begin
          key_pool[j] = $urandom;
        end
      end
      rec_weight = ((n / 50) % 2 == 0) ? 70 : 40;
      roll = $urandom_range(0, 99);
      now_tick = now_tick + $urandom_range(0, 20);
      if (roll < rec_weight) begin
        add_item(opt_pkg::MODE_RECORD,
                 ($urandom_range(0, 9) == 0) ? $urandom : now_tick,
                 ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, 7)]);
      end else if (roll < 92) begin
        if (roll % 3 != 0) begin
          add_item(opt_pkg::MODE_ACK, $urandom,
                   ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, 7)]);
        end else begin
          add_item(opt_pkg::MODE_EXPIRE,
                   ($urandom_range(0, 4) == 0) ? $urandom : now_tick - $urandom_range(0, 120),
                   $urandom);
        end
      end else if (roll < 97) begin
        // Noise: any mode with arbitrary fields.
        add_item(2'($urandom_range(0, 3)), $urandom, $urandom);
      end else begin
        add_item(opt_pkg::MODE_CLEAR, $urandom, $urandom);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    // Leave room for a long scan or anything stray before the verdict.
    repeat (40) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("ordered_pending_table test passed");
    end else begin
      $display("ordered_pending_table test failed");
    end
    $finish;
  end

endmodule

/* ordered_pending_table.f */
hdl/opt_pkg.sv
hdl/opt_ram.sv
hdl/ordered_pending_table.sv
tb/tb_top.sv
